[rtl/nfcfb_pkg.sv]
// Package for the NFC reader frame builder: beat types, frame constants, register indexes.
package nfcfb_pkg;

    // Frame bytes and overheads
    localparam logic [7:0]  FRAME_PREAMBLE    = 8'h00;
    localparam logic [7:0]  FRAME_START1      = 8'h00;
    localparam logic [7:0]  FRAME_START2      = 8'hFF;
    localparam logic [7:0]  FRAME_EXT_MARK    = 8'hFF;
    localparam logic [7:0]  FRAME_POSTAMBLE   = 8'h00;
    localparam int unsigned NORMAL_OVERHEAD   = 7;
    localparam int unsigned EXTENDED_OVERHEAD = 10;
    localparam int unsigned LIMIT_TOP         = 262;
    localparam logic [8:0]  LIMIT_RESET       = 9'd255;

    // Result burst storage
    localparam int unsigned MAX_RESULTS = 11;
    localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_MODE      = 2'd0,
        CFG_MAX_FRAME_BYTES = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       rejected;
    } t_out_item;

endpackage

[rtl/nfc_reader_frame_builder.sv]
// Top level of the NFC reader frame builder: header, checksum and trailer wrapping.
// The first byte of a burst is on the output in the cycle after its payload byte is accepted.
// Throughput: a mid-frame byte is taken every cycle while the output is not stalled; the first
// byte of a frame holds the input while its burst of 6 or 9 bytes (8 or 11 for a one-byte
// frame) drains through the one-beat output port, the last byte while its burst of 3 drains.
// Dropped bytes are consumed without an output beat.
// Reset (synchronous, active low) clears the burst, the frame state and the registers.
module nfc_reader_frame_builder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // payload input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  nfcfb_pkg::t_in_item                  i_in_item,
    // frame output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output nfcfb_pkg::t_out_item                 o_out_item,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [nfcfb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [8:0]                           i_cfg_data
);

    localparam int unsigned NR = nfcfb_pkg::MAX_RESULTS;
    localparam int unsigned IW = nfcfb_pkg::RES_IDX_W;

    // Configuration registers
    logic       r_mode;
    logic [8:0] r_max;

    // Frame state
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_sum, n_sum;
    logic        r_dropping, n_dropping;

    // Burst register: entry 0 is the beat on the output
    nfcfb_pkg::t_out_item r_buf [NR];
    nfcfb_pkg::t_out_item n_buf [NR];
    logic [IW-1:0]        r_left;
    logic [IW-1:0]        n_cnt;

    logic in_acc, out_acc, can_load;

    // Handshakes
    assign out_acc     = o_out_valid && !i_out_stall;
    assign can_load    = (r_left == '0) || ((r_left == IW'(1)) && out_acc);
    assign o_in_stall  = !can_load;
    assign in_acc      = i_in_valid && can_load;
    assign o_out_valid = (r_left != '0);
    assign o_out_item  = r_buf[0];
    assign o_cfg_ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_max  <= nfcfb_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nfcfb_pkg::CFG_FRAME_MODE:      r_mode <= i_cfg_data[0];
                nfcfb_pkg::CFG_MAX_FRAME_BYTES: r_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Length check against the clamped limit
    logic [8:0]  lim;
    logic [15:0] len;
    logic [16:0] ext_lim, ext_need, nrm_need;
    logic        bad;

    always_comb begin
        len      = i_in_item.payload_length;
        lim      = (r_max > 9'(nfcfb_pkg::LIMIT_TOP)) ? 9'(nfcfb_pkg::LIMIT_TOP) : r_max;
        ext_lim  = {lim, 8'd0} + {8'd0, lim};
        ext_need = {1'b0, len} + 17'(nfcfb_pkg::EXTENDED_OVERHEAD);
        nrm_need = {1'b0, len} + 17'(nfcfb_pkg::NORMAL_OVERHEAD);
        if (r_mode) begin
            bad = (len == '0) || (ext_need > ext_lim);
        end else begin
            bad = (len == '0) || (nrm_need > {8'd0, lim});
        end
    end

    // Build the burst of one item and the next frame state
    logic [IW-1:0] p0, p1, p2;
    logic [15:0]   left_dec;
    logic [7:0]    sum_base, sum_new;
    logic [7:0]    len_hi, len_lo;

    always_comb begin
        for (int i = 0; i < NR; i++) begin
            n_buf[i] = '0;
        end
        n_cnt        = '0;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_dropping   = r_dropping;
        len_hi       = len[15:8];
        len_lo       = len[7:0];
        p0           = '0;
        sum_base     = r_sum;
        left_dec     = r_bytes_left - 16'd1;

        priority if (r_bytes_left == '0 && bad) begin
            // Reject: one beat, drop the rest of the frame
            n_buf[0]     = '{out_byte: 8'h00, frame_end: 1'b1, rejected: 1'b1};
            n_cnt        = IW'(1);
            n_sum        = '0;
            n_bytes_left = (len > 16'd1) ? (len - 16'd1) : '0;
            n_dropping   = (len > 16'd1);
        end else if (r_bytes_left == '0) begin
            // Header, then fall into the data beat
            n_buf[0].out_byte = nfcfb_pkg::FRAME_PREAMBLE;
            n_buf[1].out_byte = nfcfb_pkg::FRAME_START1;
            n_buf[2].out_byte = nfcfb_pkg::FRAME_START2;
            if (r_mode) begin
                n_buf[3].out_byte = nfcfb_pkg::FRAME_EXT_MARK;
                n_buf[4].out_byte = nfcfb_pkg::FRAME_EXT_MARK;
                n_buf[5].out_byte = len_hi;
                n_buf[6].out_byte = len_lo;
                n_buf[7].out_byte = 8'd0 - (len_hi + len_lo);
                p0                = IW'(8);
            end else begin
                n_buf[3].out_byte = len_lo;
                n_buf[4].out_byte = 8'd0 - len_lo;
                p0                = IW'(5);
            end
            sum_base   = '0;
            left_dec   = len - 16'd1;
            n_dropping = 1'b0;
        end else if (r_dropping) begin
            // Consume a dropped byte silently
            n_bytes_left = left_dec;
            n_dropping   = (left_dec != '0);
        end else begin
            p0 = '0;
        end

        p1      = p0 + IW'(1);
        p2      = p0 + IW'(2);
        sum_new = sum_base + i_in_item.payload_byte;

        // Data beat and, on the last byte, checksum and postamble
        if (!(r_bytes_left == '0 && bad) && !(r_bytes_left != '0 && r_dropping)) begin
            n_buf[p0].out_byte = i_in_item.payload_byte;
            n_bytes_left       = left_dec;
            if (left_dec == '0) begin
                n_buf[p1].out_byte  = 8'd0 - sum_new;
                n_buf[p2].out_byte  = nfcfb_pkg::FRAME_POSTAMBLE;
                n_buf[p2].frame_end = 1'b1;
                n_cnt               = p0 + IW'(3);
                n_sum               = '0;
            end else begin
                n_cnt = p1;
                n_sum = sum_new;
            end
        end
    end

    // Advance frame state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_sum        <= '0;
            r_dropping   <= 1'b0;
        end else if (in_acc) begin
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_dropping   <= n_dropping;
        end
    end

    // Load a new burst or shift out the taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (in_acc) begin
            r_left <= n_cnt;
        end else if (out_acc) begin
            r_left <= r_left - IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < NR; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end else if (out_acc) begin
            for (int i = 0; i < NR - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

    // Checks
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= IW'(NR))
        else $error("burst count beyond burst register depth");

    a_drop_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_bytes_left != '0))
        else $error("dropping with no bytes left");

    a_reject_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.rejected) |-> (o_out_item.frame_end && r_left == IW'(1)))
        else $error("rejection beat not alone or not frame end");

    a_silent_only_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_cnt == '0) |-> (r_dropping && r_bytes_left != '0))
        else $error("item gave no result outside a dropped frame");

endmodule
